>>> hdl/itf_pkg.sv
// ----------------------------------------------------------------------------
// Integer-to-text formatter package
// Shared types, operation codes, ASCII constants and the digit lookup
// used by the formatter modules.
// ----------------------------------------------------------------------------
package itf_pkg;

    // Conversion kinds carried on the op field.
    localparam logic [1:0] OP_UDEC   = 2'd0;
    localparam logic [1:0] OP_SDEC   = 2'd1;
    localparam logic [1:0] OP_HEX_LO = 2'd2;
    localparam logic [1:0] OP_HEX_UP = 2'd3;

    // ASCII characters used in the field.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_SHIFT,
        CV_NORM
    } conv_state_t;

    typedef enum logic [1:0] {
        PAD_LEFT_JUST,
        PAD_ZERO,
        PAD_SPACE
    } pad_mode_t;

    // Field layout handed from the controller to the character emitter.
    typedef struct packed {
        pad_mode_t   mode;
        logic        upper;
        logic [15:0] pre_chars;
        logic [1:0]  pre_len;
        logic [7:0]  pad_cnt;
        logic [6:0]  n_chars;
    } emit_cfg_t;

    // ASCII character of one decimal or hex digit.
    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] alpha;
        alpha = upper ? CH_A_UP : CH_A_LO;
        if (nib < 4'd10) begin
            return CH_ZERO + {4'b0000, nib};
        end
        return alpha + {4'b0000, nib} - 8'd10;
    endfunction

endpackage

>>> hdl/itf_digit_conv.sv
// ----------------------------------------------------------------------------
// Digit converter
// Turns a binary magnitude into a row of 4-bit digits, most significant
// first, by bit-serial shift-and-add-3 for decimal or a direct load for hex,
// then strips leading zero digits one per cycle.
// ----------------------------------------------------------------------------
module itf_digit_conv #(
    parameter int VALUE_BITS = 64,
    parameter int NDIG       = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    is_hex,
    input  logic [VALUE_BITS-1:0]   mag,
    output logic                    done,
    output logic [4*NDIG-1:0]       digits,
    output logic [$clog2(NDIG+1)-1:0] dlen
);

    localparam int BW  = 4 * NDIG;
    localparam int CW  = $clog2(VALUE_BITS + 1);
    localparam int DLW = $clog2(NDIG + 1);

    itf_pkg::conv_state_t state_reg, state_next;
    logic [BW-1:0]         bcd_reg, bcd_next;
    logic [BW-1:0]         adj;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DLW-1:0]        dlen_reg, dlen_next;
    logic                  done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= itf_pkg::CV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        bcd_reg  <= bcd_next;
        bin_reg  <= bin_next;
        cnt_reg  <= cnt_next;
        dlen_reg <= dlen_next;
    end

    always_comb begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        bin_next   = bin_reg;
        cnt_next   = cnt_reg;
        dlen_next  = dlen_reg;
        done_next  = 1'b0;

        // Each BCD digit of 5 or more is corrected before the next shift.
        adj = bcd_reg;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end

        case (state_reg)
            itf_pkg::CV_IDLE: begin
                if (start) begin
                    dlen_next = DLW'(NDIG);
                    if (is_hex) begin
                        bcd_next   = BW'(mag);
                        state_next = itf_pkg::CV_NORM;
                    end else begin
                        bcd_next   = '0;
                        bin_next   = mag;
                        cnt_next   = CW'(VALUE_BITS);
                        state_next = itf_pkg::CV_SHIFT;
                    end
                end
            end
            itf_pkg::CV_SHIFT: begin
                bcd_next = {adj[BW-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = itf_pkg::CV_NORM;
                end
            end
            itf_pkg::CV_NORM: begin
                if (dlen_reg > DLW'(1) && bcd_reg[BW-1 -: 4] == 4'd0) begin
                    bcd_next  = bcd_reg << 4;
                    dlen_next = dlen_reg - DLW'(1);
                end else begin
                    done_next  = 1'b1;
                    state_next = itf_pkg::CV_IDLE;
                end
            end
            default: begin
                state_next = itf_pkg::CV_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign digits = bcd_reg;
    assign dlen   = dlen_reg;

endmodule

>>> hdl/itf_emitter.sv
// ----------------------------------------------------------------------------
// Character emitter
// Walks the prefix, padding and digits of one field and sends one character
// per request through a registered output stage.
// ----------------------------------------------------------------------------
module itf_emitter #(
    parameter int NDIG = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  itf_pkg::emit_cfg_t        cfg,
    input  logic [4*NDIG-1:0]         digits,
    input  logic [$clog2(NDIG+1)-1:0] dig_cnt,
    output logic                      done,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_char_out,
    output logic                      m_last,
    output logic [6:0]                m_length
);

    localparam int BW  = 4 * NDIG;
    localparam int DLW = $clog2(NDIG + 1);

    logic                busy_reg, busy_next;
    itf_pkg::pad_mode_t  mode_reg, mode_next;
    logic                upper_reg, upper_next;
    logic [15:0]         pre_reg, pre_next;
    logic [1:0]          pre_left_reg, pre_left_next;
    logic [7:0]          pad_left_reg, pad_left_next;
    logic [DLW-1:0]      dig_left_reg, dig_left_next;
    logic [BW-1:0]       dig_reg, dig_next;
    logic [6:0]          n_left_reg, n_left_next;
    logic [6:0]          n_total_reg, n_total_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;
    logic [6:0]          m_length_reg, m_length_next;
    logic                done_reg, done_next;

    logic step, has_pre, has_pad, has_dig, take_pre, take_pad, take_dig, is_last;
    logic [7:0] ch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            done_reg    <= done_next;
        end
        mode_reg     <= mode_next;
        upper_reg    <= upper_next;
        pre_reg      <= pre_next;
        pre_left_reg <= pre_left_next;
        pad_left_reg <= pad_left_next;
        dig_left_reg <= dig_left_next;
        dig_reg      <= dig_next;
        n_left_reg   <= n_left_next;
        n_total_reg  <= n_total_next;
        m_char_reg   <= m_char_next;
        m_last_reg   <= m_last_next;
        m_length_reg <= m_length_next;
    end

    always_comb begin
        step    = busy_reg && (!m_valid_reg || m_ready);
        has_pre = pre_left_reg != 2'd0;
        has_pad = pad_left_reg != 8'd0;
        has_dig = dig_left_reg != DLW'(0);
        is_last = n_left_reg == 7'd1;

        // The order of the three parts depends on the justification.
        case (mode_reg)
            itf_pkg::PAD_LEFT_JUST: begin
                take_pre = has_pre;
                take_pad = 1'b0;
                take_dig = !has_pre && has_dig;
            end
            itf_pkg::PAD_ZERO: begin
                take_pre = has_pre;
                take_pad = !has_pre && has_pad;
                take_dig = !has_pre && !has_pad && has_dig;
            end
            default: begin
                take_pad = has_pad;
                take_pre = !has_pad && has_pre;
                take_dig = !has_pad && !has_pre && has_dig;
            end
        endcase

        if (take_pre) begin
            ch = pre_reg[15:8];
        end else if (take_dig) begin
            ch = itf_pkg::digit_char(dig_reg[BW-1 -: 4], upper_reg);
        end else if (take_pad && mode_reg == itf_pkg::PAD_ZERO) begin
            ch = itf_pkg::CH_ZERO;
        end else begin
            ch = itf_pkg::CH_SPACE;
        end

        busy_next     = busy_reg;
        mode_next     = mode_reg;
        upper_next    = upper_reg;
        pre_next      = pre_reg;
        pre_left_next = pre_left_reg;
        pad_left_next = pad_left_reg;
        dig_left_next = dig_left_reg;
        dig_next      = dig_reg;
        n_left_next   = n_left_reg;
        n_total_next  = n_total_reg;
        m_valid_next  = m_valid_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        m_length_next = m_length_reg;
        done_next     = 1'b0;

        if (start) begin
            busy_next     = 1'b1;
            mode_next     = cfg.mode;
            upper_next    = cfg.upper;
            pre_next      = cfg.pre_chars;
            pre_left_next = cfg.pre_len;
            pad_left_next = cfg.pad_cnt;
            dig_left_next = dig_cnt;
            dig_next      = digits;
            n_left_next   = cfg.n_chars;
            n_total_next  = cfg.n_chars;
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (step) begin
            m_valid_next  = 1'b1;
            m_char_next   = ch;
            m_last_next   = is_last;
            m_length_next = is_last ? n_total_reg : 7'd0;
            n_left_next   = n_left_reg - 7'd1;
            if (take_pre) begin
                pre_next      = pre_reg << 8;
                pre_left_next = pre_left_reg - 2'd1;
            end
            if (take_pad) begin
                pad_left_next = pad_left_reg - 8'd1;
            end
            if (take_dig) begin
                dig_next      = dig_reg << 4;
                dig_left_next = dig_left_reg - DLW'(1);
            end
            if (is_last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done       = done_reg;
    assign m_valid    = m_valid_reg;
    assign m_char_out = m_char_reg;
    assign m_last     = m_last_reg;
    assign m_length   = m_length_reg;

endmodule

>>> hdl/integer_to_text_formatter.sv
// ----------------------------------------------------------------------------
// Integer-to-text formatter
// Formats one integer request as printf-style decimal or hex text and sends
// the field one ASCII character per output request.
// ----------------------------------------------------------------------------
// Usage: a request on the s_ channel carries the value, the conversion kind,
// the justification and sign flags, the minimum width and the room left in
// the output buffer. The m_ channel returns the characters of the field in
// order; m_last marks the final one and m_length then gives the count.
// A request whose room is zero produces no output at all.
// Sequence: after the request is taken, decimal values go through
// bit-serial binary-to-BCD shifting (hex digits are loaded directly),
// leading zeros are stripped, the digits are handed over, the field is
// laid out, and the n characters of the field are then sent in order.
// One request is worked on at a time; s_ready rises again in the cycle
// after the last character is in the output register.
// Reset (aresetn low, synchronous) drops any request in flight and empties
// the output register. When the receiver holds m_ready low, the current
// character stays on the m_ ports and the emitter waits.
// ----------------------------------------------------------------------------
module integer_to_text_formatter #(
    parameter int MAX_CHARS  = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value,
    input  logic [1:0]  s_op,
    input  logic        s_left_justify,
    input  logic        s_zero_pad,
    input  logic        s_plus_sign,
    input  logic        s_space_sign,
    input  logic        s_alt_prefix,
    input  logic [7:0]  s_width,
    input  logic [6:0]  s_space,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_out,
    output logic        m_last,
    output logic [6:0]  m_length
);

    // Number of decimal digits of the widest magnitude; 1233/4096 is just
    // below log10(2), so this is floor(VALUE_BITS * log10(2)) + 1.
    localparam int NDIG = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int DLW  = $clog2(NDIG + 1);
    localparam logic [8:0] MAX_W = 9'(MAX_CHARS);

    itf_pkg::top_state_t state_reg, state_next;

    // Layout of the field, captured when the request is taken.
    logic [15:0] pre_chars_reg, pre_chars_next;
    logic [1:0]  pre_len_reg, pre_len_next;
    logic        left_reg, left_next;
    logic        zero_reg, zero_next;
    logic        upper_reg, upper_next;
    logic [7:0]  width_reg, width_next;
    logic [6:0]  limit_reg, limit_next;

    logic                  accept;
    logic [VALUE_BITS-1:0] v;
    logic                  is_hex, neg, nonzero;
    logic [VALUE_BITS-1:0] mag;
    logic [15:0]           pre_chars_c;
    logic [1:0]            pre_len_c;

    logic                  conv_done;
    logic [4*NDIG-1:0]     digits;
    logic [DLW-1:0]        dlen;

    logic [7:0]            body, pad, total;
    logic [6:0]            n_chars;
    itf_pkg::emit_cfg_t    cfg;
    logic                  emit_start, emit_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= itf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pre_chars_reg <= pre_chars_next;
        pre_len_reg   <= pre_len_next;
        left_reg      <= left_next;
        zero_reg      <= zero_next;
        upper_reg     <= upper_next;
        width_reg     <= width_next;
        limit_reg     <= limit_next;
    end

    // Sign, magnitude and prefix of the incoming request.
    always_comb begin
        v       = s_value[VALUE_BITS-1:0];
        is_hex  = s_op == itf_pkg::OP_HEX_LO || s_op == itf_pkg::OP_HEX_UP;
        neg     = s_op == itf_pkg::OP_SDEC && v[VALUE_BITS-1];
        nonzero = |v;
        // The most negative signed value negates to itself, which read as
        // unsigned is exactly its magnitude.
        mag     = neg ? (~v + VALUE_BITS'(1)) : v;

        pre_chars_c = 16'h0000;
        pre_len_c   = 2'd0;
        if (is_hex) begin
            if (s_alt_prefix && nonzero) begin
                pre_chars_c = {itf_pkg::CH_ZERO,
                               (s_op == itf_pkg::OP_HEX_UP) ? itf_pkg::CH_X_UP
                                                            : itf_pkg::CH_X_LO};
                pre_len_c   = 2'd2;
            end
        end else if (neg) begin
            pre_chars_c = {itf_pkg::CH_MINUS, 8'h00};
            pre_len_c   = 2'd1;
        end else if (s_plus_sign) begin
            pre_chars_c = {itf_pkg::CH_PLUS, 8'h00};
            pre_len_c   = 2'd1;
        end else if (s_space_sign) begin
            pre_chars_c = {itf_pkg::CH_SPACE, 8'h00};
            pre_len_c   = 2'd1;
        end
    end

    // Field length: prefix plus digits, padded up to the width, then cut to
    // the room that is left.
    always_comb begin
        body    = 8'(pre_len_reg) + 8'(dlen);
        pad     = (width_reg > body) ? (width_reg - body) : 8'd0;
        total   = body + pad;
        n_chars = (total < {1'b0, limit_reg}) ? total[6:0] : limit_reg;

        cfg.mode      = left_reg ? itf_pkg::PAD_LEFT_JUST
                                 : (zero_reg ? itf_pkg::PAD_ZERO : itf_pkg::PAD_SPACE);
        cfg.upper     = upper_reg;
        cfg.pre_chars = pre_chars_reg;
        cfg.pre_len   = pre_len_reg;
        cfg.pad_cnt   = pad;
        cfg.n_chars   = n_chars;
    end

    always_comb begin
        state_next     = state_reg;
        pre_chars_next = pre_chars_reg;
        pre_len_next   = pre_len_reg;
        left_next      = left_reg;
        zero_next      = zero_reg;
        upper_next     = upper_reg;
        width_next     = width_reg;
        limit_next     = limit_reg;
        s_ready        = 1'b0;
        emit_start     = 1'b0;

        case (state_reg)
            itf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    pre_chars_next = pre_chars_c;
                    pre_len_next   = pre_len_c;
                    left_next      = s_left_justify;
                    zero_next      = s_zero_pad;
                    upper_next     = s_op == itf_pkg::OP_HEX_UP;
                    width_next     = s_width;
                    limit_next     = ({2'b00, s_space} > MAX_W) ? MAX_W[6:0] : s_space;
                    state_next     = itf_pkg::ST_CONV;
                end
            end
            itf_pkg::ST_CONV: begin
                if (conv_done) begin
                    state_next = itf_pkg::ST_PREP;
                end
            end
            itf_pkg::ST_PREP: begin
                if (n_chars == 7'd0) begin
                    state_next = itf_pkg::ST_IDLE;
                end else begin
                    emit_start = 1'b1;
                    state_next = itf_pkg::ST_EMIT;
                end
            end
            itf_pkg::ST_EMIT: begin
                if (emit_done) begin
                    state_next = itf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = itf_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    itf_digit_conv #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .is_hex  (is_hex),
        .mag     (mag),
        .done    (conv_done),
        .digits  (digits),
        .dlen    (dlen)
    );

    itf_emitter #(
        .NDIG (NDIG)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (emit_start),
        .cfg        (cfg),
        .digits     (digits),
        .dig_cnt    (dlen),
        .done       (emit_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_out (m_char_out),
        .m_last     (m_last),
        .m_length   (m_length)
    );

endmodule

>>> hdl/itf_checker.sv
// ----------------------------------------------------------------------------
// Formatter port checker
// Watches the ports of the formatter and flags broken sequencing of
// requests and characters.
// ----------------------------------------------------------------------------
module itf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_char_out,
    input logic       m_last,
    input logic [6:0] m_length
);

    // A new request is never taken while a field is still being sent.
    a_no_accept_mid_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("request accepted in the middle of a field");

    // Only the final character of a field reports a length, and it is nonzero.
    a_length_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last ? (m_length != 7'd0) : (m_length == 7'd0)))
        else $error("length reported on the wrong character");

    // A taken request keeps the input closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open right after a request");

    // A stalled character holds.
    a_output_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_out) && $stable(m_last)
                                && $stable(m_length))
        else $error("stalled character changed");

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (.*);

>>> dv/tb_integer_to_text_formatter.sv
// ----------------------------------------------------------------------------
// Integer-to-text formatter testbench
// Sends formatting requests to the formatter and checks every character it
// returns against a field built here for each accepted request. Directed
// requests cover the flag and boundary cases. Random requests follow, with
// random gaps on the request side and random stalls on the character side.
// ----------------------------------------------------------------------------
module tb_integer_to_text_formatter;

    // The formatter clips every field to this many characters.
    localparam int FIELD_MAX    = 64;
    localparam int RANDOM_REQS  = 320;
    // Longest request: 64 value bits of shifting, digit cleanup and layout.
    // The quiet time at the end covers that, plus a zero-room request that
    // is still in flight.
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 2000000;

    // One formatting request as it travels on the s_ ports.
    typedef struct {
        logic [63:0] value;
        logic [1:0]  op;
        logic        left;
        logic        zero;
        logic        plus;
        logic        spc;
        logic        alt;
        logic [7:0]  width;
        logic [6:0]  space;
    } fmt_req_t;

    // One character of a field as it should appear on the m_ ports.
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic [6:0] len;
    } text_char_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [63:0] s_value        = '0;
    logic [1:0]  s_op           = itf_pkg::OP_UDEC;
    logic        s_left_justify = 1'b0;
    logic        s_zero_pad     = 1'b0;
    logic        s_plus_sign    = 1'b0;
    logic        s_space_sign   = 1'b0;
    logic        s_alt_prefix   = 1'b0;
    logic [7:0]  s_width        = '0;
    logic [6:0]  s_space        = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_char_out;
    logic        m_last;
    logic [6:0]  m_length;

    fmt_req_t   pending_reqs[$];
    text_char_t expected_text[$];
    fmt_req_t   next_req;

    int unsigned reqs_issued   = 0;
    int unsigned reqs_accepted = 0;
    int unsigned chars_taken   = 0;
    int unsigned chars_seen_rx = 0;
    int unsigned send_gap      = 0;
    int unsigned rx_stall      = 0;
    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    bit          send_calm     = 1'b0;
    bit          rx_calm       = 1'b0;

    integer_to_text_formatter DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_op           (s_op),
        .s_left_justify (s_left_justify),
        .s_zero_pad     (s_zero_pad),
        .s_plus_sign    (s_plus_sign),
        .s_space_sign   (s_space_sign),
        .s_alt_prefix   (s_alt_prefix),
        .s_width        (s_width),
        .s_space        (s_space),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_out     (m_char_out),
        .m_last         (m_last),
        .m_length       (m_length)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Builds the text field of one request and appends its characters to the
    // expected stream. The field is laid out as pad, prefix and digits, with
    // the order depending on justification and zero padding.
    function automatic void format_field(input fmt_req_t r);
        logic [7:0]  prefix[2];
        logic [7:0]  digits_rev[24];
        logic [63:0] mag;
        string       digit_set;
        bit          negative;
        int          plen;
        int          dlen;
        int          body;
        int          pad;
        int          total;
        int          room;
        int          count;
        int          pos;
        text_char_t  c;

        plen = 0;
        dlen = 0;
        if (r.op == itf_pkg::OP_HEX_UP) begin
            digit_set = "0123456789ABCDEF";
        end else begin
            digit_set = "0123456789abcdef";
        end

        if (r.op == itf_pkg::OP_UDEC || r.op == itf_pkg::OP_SDEC) begin
            // Only signed decimal treats bit 63 as a sign; the most negative
            // value negates onto itself and prints as its full magnitude.
            negative = (r.op == itf_pkg::OP_SDEC) && r.value[63];
            mag = negative ? (64'd0 - r.value) : r.value;
            if (negative) begin
                prefix[0] = itf_pkg::CH_MINUS;
                plen = 1;
            end else if (r.plus) begin
                prefix[0] = itf_pkg::CH_PLUS;
                plen = 1;
            end else if (r.spc) begin
                prefix[0] = itf_pkg::CH_SPACE;
                plen = 1;
            end
            do begin
                digits_rev[dlen] = digit_set[int'(mag % 64'd10)];
                dlen = dlen + 1;
                mag = mag / 64'd10;
            end while (mag != 0);
        end else begin
            // Hex ignores the sign flags; zero never gets the 0x prefix.
            if (r.alt && r.value != 0) begin
                prefix[0] = itf_pkg::CH_ZERO;
                prefix[1] = (r.op == itf_pkg::OP_HEX_UP) ? itf_pkg::CH_X_UP
                                                         : itf_pkg::CH_X_LO;
                plen = 2;
            end
            mag = r.value;
            do begin
                digits_rev[dlen] = digit_set[int'(mag[3:0])];
                dlen = dlen + 1;
                mag = mag >> 4;
            end while (mag != 0);
        end

        body  = plen + dlen;
        pad   = (int'(r.width) > body) ? int'(r.width) - body : 0;
        total = body + pad;
        room  = (int'(r.space) > FIELD_MAX) ? FIELD_MAX : int'(r.space);
        count = (total < room) ? total : room;

        for (int i = 0; i < count; i++) begin
            pos = i;
            if (r.left) begin
                // Left-justified: prefix, digits, then trailing spaces.
                if (pos < plen) begin
                    c.ch = prefix[pos];
                end else if (pos - plen < dlen) begin
                    c.ch = digits_rev[dlen - 1 - (pos - plen)];
                end else begin
                    c.ch = itf_pkg::CH_SPACE;
                end
            end else if (r.zero) begin
                // Zero padding goes between the prefix and the digits.
                if (pos < plen) begin
                    c.ch = prefix[pos];
                end else if (pos - plen < pad) begin
                    c.ch = itf_pkg::CH_ZERO;
                end else begin
                    c.ch = digits_rev[dlen - 1 - (pos - plen - pad)];
                end
            end else begin
                // Plain right justification: leading spaces, prefix, digits.
                if (pos < pad) begin
                    c.ch = itf_pkg::CH_SPACE;
                end else if (pos - pad < plen) begin
                    c.ch = prefix[pos - pad];
                end else begin
                    c.ch = digits_rev[dlen - 1 - (pos - pad - plen)];
                end
            end
            c.last = (i + 1 == count);
            c.len  = c.last ? 7'(count) : 7'd0;
            expected_text.push_back(c);
        end
    endfunction

    task automatic add_req(input logic [63:0] value, input logic [1:0] op,
                           input bit left, input bit zero, input bit plus,
                           input bit spc, input bit alt,
                           input logic [7:0] width, input logic [6:0] space);
        fmt_req_t r;
        r = '{value: value, op: op, left: left, zero: zero, plus: plus,
              spc: spc, alt: alt, width: width, space: space};
        pending_reqs.push_back(r);
    endtask

    // Random request. Values mix small numbers, small negatives, full-width
    // patterns and powers of two and ten near their edges, so that the digit
    // count spans its whole range and every value bit toggles.
    task automatic add_random_req();
        logic [63:0] v;
        logic [7:0]  w;
        logic [6:0]  room;
        int          pick;

        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 999));
            1: v = {$urandom, $urandom};
            2: v = 64'd0 - 64'($urandom_range(1, 99999));
            3: v = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
            4: begin
                v = 64'd1;
                repeat ($urandom_range(0, 19)) v = v * 64'd10;
                v = v - 64'($urandom_range(0, 1));
            end
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase

        // Most widths stay near the natural field size; a few go wide.
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            w = 8'($urandom_range(0, 24));
        end else if (pick < 9) begin
            w = 8'($urandom_range(0, 70));
        end else begin
            w = 8'($urandom_range(0, 255));
        end

        // Room is mostly in range, sometimes above the clip point, rarely zero.
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            room = 7'd0;
        end else if (pick < 3) begin
            room = 7'($urandom_range(65, 127));
        end else begin
            room = 7'($urandom_range(1, 64));
        end

        add_req(v, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), w, room);
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        mismatches = mismatches + 1;
    endtask

    // Request driver. Inputs change on the falling edge. A request stays on
    // the ports until the monitor has seen it accepted; each request then
    // waits out its own gap, and calm stretches send back to back.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && reqs_accepted != reqs_issued) begin
            // Still waiting for the handshake; hold everything.
        end else if (send_gap != 0) begin
            s_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_reqs.size() != 0) begin
            next_req = pending_reqs.pop_front();
            s_value        <= next_req.value;
            s_op           <= next_req.op;
            s_left_justify <= next_req.left;
            s_zero_pad     <= next_req.zero;
            s_plus_sign    <= next_req.plus;
            s_space_sign   <= next_req.spc;
            s_alt_prefix   <= next_req.alt;
            s_width        <= next_req.width;
            s_space        <= next_req.space;
            s_valid        <= 1'b1;
            reqs_issued    <= reqs_issued + 1;
            if ($urandom_range(0, 15) == 0) begin
                send_calm = !send_calm;
            end
            send_gap <= send_calm ? 0 : $urandom_range(0, 19);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Character receiver. After each character it takes, it may hold m_ready
    // low for a drawn number of cycles before taking the next one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_ready) begin
            if (chars_taken != chars_seen_rx) begin
                chars_seen_rx = chars_taken;
                if ($urandom_range(0, 31) == 0) begin
                    rx_calm = !rx_calm;
                end
                rx_stall = rx_calm ? 0 : $urandom_range(0, 19);
                if (rx_stall != 0) begin
                    m_ready <= 1'b0;
                end
            end
        end else if (rx_stall > 1) begin
            rx_stall = rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor. Handshakes are sampled on the rising edge. Each character is
    // checked before a request accepted in the same cycle adds its field, so
    // a character can never be matched against a field that was just taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                chars_taken <= chars_taken + 1;
                if (expected_text.size() == 0) begin
                    $display("%0t: character expected none, got %0h last %0b length %0d",
                             $time, m_char_out, m_last, m_length);
                    mismatches = mismatches + 1;
                end else begin
                    if (m_char_out !== expected_text[0].ch) begin
                        report_field("char_out", expected_text[0].ch, m_char_out);
                    end
                    if (m_last !== expected_text[0].last) begin
                        report_field("last", 8'(expected_text[0].last), 8'(m_last));
                    end
                    if (m_length !== expected_text[0].len) begin
                        report_field("length", 8'(expected_text[0].len), 8'(m_length));
                    end
                    void'(expected_text.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                reqs_accepted <= reqs_accepted + 1;
                format_field('{value: s_value, op: s_op, left: s_left_justify,
                               zero: s_zero_pad, plus: s_plus_sign,
                               spc: s_space_sign, alt: s_alt_prefix,
                               width: s_width, space: s_space});
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("integer_to_text_formatter: mismatch");
            $finish;
        end
    end

    initial begin
        // Directed requests: field extremes, each conversion and flag mix,
        // padding styles, truncation and the room corner cases.
        add_req(64'd0, itf_pkg::OP_UDEC, 0, 0, 0, 0, 0, 8'd0, 7'd64);
        add_req('1, itf_pkg::OP_UDEC, 0, 0, 0, 0, 0, 8'd0, 7'd64);
        // Most negative value: signed gets '-', unsigned prints plainly.
        add_req(64'h8000_0000_0000_0000, itf_pkg::OP_SDEC, 0, 0, 0, 0, 0, 8'd0, 7'd64);
        add_req(64'h8000_0000_0000_0000, itf_pkg::OP_UDEC, 0, 0, 0, 0, 0, 8'd0, 7'd64);
        add_req(64'h7FFF_FFFF_FFFF_FFFF, itf_pkg::OP_SDEC, 0, 0, 1, 0, 0, 8'd0, 7'd64);
        add_req(64'd10000000000000000000, itf_pkg::OP_UDEC, 0, 0, 0, 0, 0, 8'd0, 7'd64);
        // Zeros go after the sign.
        add_req('1, itf_pkg::OP_SDEC, 0, 1, 0, 0, 0, 8'd10, 7'd64);
        add_req(64'd42, itf_pkg::OP_SDEC, 0, 0, 1, 0, 0, 8'd6, 7'd64);
        add_req(64'd42, itf_pkg::OP_SDEC, 0, 0, 0, 1, 0, 8'd0, 7'd64);
        add_req(64'd42, itf_pkg::OP_SDEC, 0, 1, 1, 1, 0, 8'd8, 7'd64);
        // The hex prefix flag has no effect on decimal.
        add_req(64'd42, itf_pkg::OP_UDEC, 0, 0, 0, 0, 1, 8'd5, 7'd64);
        // Zeros go after 0x; the sign flags have no effect on hex.
        add_req(64'hDEAD_BEEF, itf_pkg::OP_HEX_LO, 0, 1, 0, 0, 1, 8'd14, 7'd64);
        add_req(64'hDEAD_BEEF, itf_pkg::OP_HEX_UP, 0, 0, 1, 1, 1, 8'd14, 7'd64);
        add_req('1, itf_pkg::OP_HEX_UP, 0, 0, 0, 0, 1, 8'd0, 7'd64);
        // Zero in hex never gets a prefix.
        add_req(64'd0, itf_pkg::OP_HEX_LO, 0, 1, 0, 0, 1, 8'd4, 7'd64);
        add_req(64'd0, itf_pkg::OP_HEX_UP, 0, 0, 0, 0, 1, 8'd0, 7'd64);
        // Left justification overrides zero padding.
        add_req(64'd0 - 64'd12345, itf_pkg::OP_SDEC, 1, 1, 0, 0, 0, 8'd30, 7'd64);
        add_req(64'hABC, itf_pkg::OP_HEX_LO, 1, 0, 0, 0, 1, 8'd12, 7'd64);
        // Widest width is cut to the room; width of one adds nothing.
        add_req(64'd7, itf_pkg::OP_UDEC, 0, 0, 0, 0, 0, 8'd255, 7'd64);
        add_req(64'd7, itf_pkg::OP_UDEC, 0, 0, 0, 0, 0, 8'd1, 7'd64);
        // Room above the clip point counts as the clip point.
        add_req(64'd99, itf_pkg::OP_UDEC, 0, 1, 0, 0, 0, 8'd200, 7'd127);
        // No room at all produces no characters.
        add_req(64'd5, itf_pkg::OP_UDEC, 0, 0, 0, 0, 0, 8'd0, 7'd0);
        add_req(64'd0 - 64'd12345, itf_pkg::OP_SDEC, 0, 0, 0, 0, 0, 8'd0, 7'd3);
        add_req(64'd12345, itf_pkg::OP_UDEC, 0, 0, 0, 0, 0, 8'd0, 7'd1);
        add_req(64'h1234_5678_9ABC_DEF0, itf_pkg::OP_HEX_LO, 0, 0, 0, 1, 0, 8'd20, 7'd65);

        repeat (RANDOM_REQS) add_random_req();

        // Single reset pulse, released on a falling edge.
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait until every request is taken and every character is back.
        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_text.size() != 0) @(posedge aclk);
        // Any stray characters after this point are caught by the monitor.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_text.size() != 0) begin
            $display("%0t: %0d expected characters never arrived",
                     $time, expected_text.size());
            mismatches = mismatches + 1;
        end
        if (mismatches == 0) begin
            $display("integer_to_text_formatter: match");
        end else begin
            $display("integer_to_text_formatter: mismatch");
        end
        $finish;
    end

endmodule
